>>> hdl/pgmhp_pkg.sv
// pgmhp_pkg: shared types and constants of the greymap header and pixel parser
// used by every module under hdl; depends on nothing

package pgmhp_pkg;

  // longest header token, in characters, before it is flagged as an error
  localparam int unsigned MaxTokenChars = 15;
  // token length counter width (holds up to 63)
  localparam int unsigned TokLenW = 6;

  // character codes
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_PIXELS = 3'd4,
    PH_DONE   = 3'd5,
    PH_HALT   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] magic_code;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] max_value;
    logic [7:0]  pixel_value;
    logic [15:0] pixel_row;
    logic [15:0] pixel_col;
    logic        image_done;
  } result_t;

  // handshake between the input register, the parse core and the result register
  typedef struct packed {
    logic valid;    // input register holds an item
    logic advance;  // item is consumed this cycle
  } stage_ctrl_t;

endpackage

>>> hdl/pgm_header_and_pixel_parser.sv
// pgm_header_and_pixel_parser: top level of the binary greymap byte parser
// depends on pgmhp_pkg, pgmhp_in_reg, pgmhp_core, pgmhp_out_reg
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_byte_i, new_file_i
//   out     | output    | out_valid_o / out_stall_i| kind_o, header fields, pixel fields
//
// one byte item per cycle sustained while out_stall_i holds back no result; an
// item that yields a result goes to out_valid_o via the input register, then the result register
// the parse step is one pass of small logic: compares, one x10 add, counters
// reset (rst_ni, async, active low) clears the parse state and both valid bits
// in_stall_o rises only while the input register holds an item that yields a
// result and the result register is full and stalled

module pgm_header_and_pixel_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        new_file_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] magic_code_o,
  output logic [15:0] img_width_o,
  output logic [15:0] img_height_o,
  output logic [15:0] max_value_o,
  output logic [7:0]  pixel_value_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_col_o,
  output logic        image_done_o
);

  pgmhp_pkg::item_t       in_item;
  pgmhp_pkg::item_t       s1_item;
  pgmhp_pkg::stage_ctrl_t s1_ctrl;
  pgmhp_pkg::result_t     step_result;
  pgmhp_pkg::result_t     out_result;
  logic                   s1_valid;
  logic                   step_has_result;
  logic                   out_free;

  assign in_item.in_byte  = in_byte_i;
  assign in_item.new_file = new_file_i;

  // the held item moves on unless its result has nowhere to go
  assign s1_ctrl.valid   = s1_valid;
  assign s1_ctrl.advance = s1_valid && (!step_has_result || out_free);

  pgmhp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (s1_ctrl.advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // header tokenizer, number parse and pixel counters
  pgmhp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (s1_item),
    .ctrl_i       (s1_ctrl),
    .has_result_o (step_has_result),
    .result_o     (step_result)
  );

  pgmhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_ctrl.advance && step_has_result),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign kind_o        = out_result.kind;
  assign magic_code_o  = out_result.magic_code;
  assign img_width_o   = out_result.img_width;
  assign img_height_o  = out_result.img_height;
  assign max_value_o   = out_result.max_value;
  assign pixel_value_o = out_result.pixel_value;
  assign pixel_row_o   = out_result.pixel_row;
  assign pixel_col_o   = out_result.pixel_col;
  assign image_done_o  = out_result.image_done;

`ifndef SYNTHESIS
  // an error item carries nothing from the header
  a_error_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pgmhp_pkg::KIND_ERROR |->
      magic_code_o == '0 && img_width_o == '0 && img_height_o == '0 &&
      max_value_o == '0 && image_done_o == 1'b0)
    else $error("error item with nonzero fields");

  // a pixel lies inside the image
  a_pixel_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pgmhp_pkg::KIND_PIXEL |->
      pixel_col_o < img_width_o && pixel_row_o < img_height_o)
    else $error("pixel position outside image");

  // header done flag follows an empty image
  a_header_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pgmhp_pkg::KIND_HEADER |->
      image_done_o == (img_width_o == '0 || img_height_o == '0) &&
      pixel_row_o == '0 && pixel_col_o == '0)
    else $error("header item fields inconsistent");
`endif

endmodule

>>> hdl/pgmhp_in_reg.sv
// pgmhp_in_reg: input register of the parser, holds one accepted item
// depends on pgmhp_pkg

module pgmhp_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pgmhp_pkg::item_t    item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output pgmhp_pkg::item_t    item_o
);

  logic             valid_q, valid_d;
  pgmhp_pkg::item_t item_q;
  logic             accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/pgmhp_core.sv
// pgmhp_core: parse state and single-pass step logic for one byte
// depends on pgmhp_pkg

module pgmhp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pgmhp_pkg::item_t     item_i,
  input  pgmhp_pkg::stage_ctrl_t ctrl_i,
  output logic                 has_result_o,
  output pgmhp_pkg::result_t   result_o
);

  pgmhp_pkg::phase_e phase_q, phase_d, eff_phase;
  logic                       in_token_q, in_token_d, eff_in_token;
  logic                       in_comment_q, in_comment_d, eff_in_comment;
  logic [pgmhp_pkg::TokLenW-1:0] tok_len_q, tok_len_d, eff_tok_len;
  logic [15:0]                acc_q, acc_d, eff_acc;
  logic                       stopped_q, stopped_d, eff_stopped;
  logic [15:0]                magic_q, magic_d, eff_magic;
  logic [15:0]                width_q, width_d, eff_width;
  logic [15:0]                height_q, height_d, eff_height;
  logic [15:0]                maxv_q, maxv_d, eff_maxv;
  logic [15:0]                row_q, row_d, eff_row;
  logic [15:0]                col_q, col_d, eff_col;

  logic [7:0]  b;
  logic        nf;
  logic        is_ws;
  // character take inputs and outputs
  logic [pgmhp_pkg::TokLenW-1:0] tc_len;
  logic [15:0] tc_acc;
  logic        tc_stop;
  logic [15:0] tk_acc, tk_magic;
  logic        tk_stop;
  logic [19:0] acc_x10;
  logic        is_digit;
  logic [16:0] col_inc, row_inc;
  logic        last_pix;
  logic        empty;

  assign b  = item_i.in_byte;
  assign nf = item_i.new_file;
  assign is_ws = (b == pgmhp_pkg::ChSpace) ||
                 ((b >= pgmhp_pkg::ChTab) && (b <= pgmhp_pkg::ChCr));

  // new_file clears everything before the byte is parsed
  always_comb begin
    eff_phase      = nf ? pgmhp_pkg::PH_MAGIC : phase_q;
    eff_in_token   = nf ? 1'b0 : in_token_q;
    eff_in_comment = nf ? 1'b0 : in_comment_q;
    eff_tok_len    = nf ? '0 : tok_len_q;
    eff_acc        = nf ? '0 : acc_q;
    eff_stopped    = nf ? 1'b0 : stopped_q;
    eff_magic      = nf ? '0 : magic_q;
    eff_width      = nf ? '0 : width_q;
    eff_height     = nf ? '0 : height_q;
    eff_maxv       = nf ? '0 : maxv_q;
    eff_row        = nf ? '0 : row_q;
    eff_col        = nf ? '0 : col_q;
  end

  // a fresh token starts from zero
  assign tc_len  = eff_in_token ? eff_tok_len : '0;
  assign tc_acc  = eff_in_token ? eff_acc : '0;
  assign tc_stop = eff_in_token ? eff_stopped : 1'b0;

  assign is_digit = (b >= pgmhp_pkg::ChZero) && (b <= pgmhp_pkg::ChNine);
  assign acc_x10  = 20'({tc_acc, 3'b000}) + 20'({tc_acc, 1'b0}) +
                    20'(b[3:0]);

  // one token character: magic letters or an atoi digit
  always_comb begin
    tk_acc   = tc_acc;
    tk_stop  = tc_stop;
    tk_magic = eff_magic;
    if (eff_phase == pgmhp_pkg::PH_MAGIC) begin
      if (tc_len == '0) begin
        tk_magic = {b, 8'h00};
      end else if (tc_len == pgmhp_pkg::TokLenW'(1)) begin
        tk_magic = {eff_magic[15:8], b};
      end
    end else if (!tc_stop) begin
      if (tc_len == '0 && b == pgmhp_pkg::ChPlus) begin
        tk_stop = 1'b0;
      end else if (tc_len == '0 && b == pgmhp_pkg::ChMinus) begin
        tk_stop = 1'b1;
      end else if (is_digit) begin
        tk_acc = (acc_x10[19:16] != 4'd0) ? 16'hFFFF : acc_x10[15:0];
      end else begin
        tk_stop = 1'b1;
      end
    end
  end

  assign col_inc  = {1'b0, eff_col} + 17'd1;
  assign row_inc  = {1'b0, eff_row} + 17'd1;
  assign last_pix = (row_inc == {1'b0, eff_height}) && (col_inc == {1'b0, eff_width});
  assign empty    = (eff_width == '0) || (eff_height == '0);

  // next state
  always_comb begin
    phase_d      = eff_phase;
    in_token_d   = eff_in_token;
    in_comment_d = eff_in_comment;
    tok_len_d    = eff_tok_len;
    acc_d        = eff_acc;
    stopped_d    = eff_stopped;
    magic_d      = eff_magic;
    width_d      = eff_width;
    height_d     = eff_height;
    maxv_d       = eff_maxv;
    row_d        = eff_row;
    col_d        = eff_col;

    case (eff_phase)
      pgmhp_pkg::PH_DONE, pgmhp_pkg::PH_HALT: begin
        phase_d = eff_phase;
      end
      pgmhp_pkg::PH_PIXELS: begin
        if (last_pix) begin
          phase_d = pgmhp_pkg::PH_DONE;
        end else if (col_inc >= {1'b0, eff_width}) begin
          col_d = '0;
          row_d = row_inc[15:0];
        end else begin
          col_d = col_inc[15:0];
        end
      end
      default: begin
        if (!eff_in_token) begin
          if (eff_in_comment) begin
            if (b == pgmhp_pkg::ChNewline) begin
              in_comment_d = 1'b0;
            end
          end else if (b == pgmhp_pkg::ChHash) begin
            in_comment_d = 1'b1;
          end else if (!is_ws) begin
            in_token_d = 1'b1;
            tok_len_d  = pgmhp_pkg::TokLenW'(1);
            acc_d      = tk_acc;
            stopped_d  = tk_stop;
            magic_d    = tk_magic;
          end
        end else if (!is_ws) begin
          if (eff_tok_len >= pgmhp_pkg::TokLenW'(pgmhp_pkg::MaxTokenChars)) begin
            // token too long: clear everything and halt until next file
            phase_d      = pgmhp_pkg::PH_HALT;
            in_token_d   = 1'b0;
            in_comment_d = 1'b0;
            tok_len_d    = '0;
            acc_d        = '0;
            stopped_d    = 1'b0;
            magic_d      = '0;
            width_d      = '0;
            height_d     = '0;
            maxv_d       = '0;
            row_d        = '0;
            col_d        = '0;
          end else begin
            tok_len_d = eff_tok_len + pgmhp_pkg::TokLenW'(1);
            acc_d     = tk_acc;
            stopped_d = tk_stop;
            magic_d   = tk_magic;
          end
        end else begin
          // whitespace ends the token
          in_token_d = 1'b0;
          tok_len_d  = '0;
          case (eff_phase)
            pgmhp_pkg::PH_MAGIC: begin
              phase_d = pgmhp_pkg::PH_WIDTH;
            end
            pgmhp_pkg::PH_WIDTH: begin
              width_d = eff_acc;
              phase_d = pgmhp_pkg::PH_HEIGHT;
            end
            pgmhp_pkg::PH_HEIGHT: begin
              height_d = eff_acc;
              phase_d  = pgmhp_pkg::PH_MAXVAL;
            end
            default: begin
              maxv_d  = eff_acc;
              row_d   = '0;
              col_d   = '0;
              phase_d = empty ? pgmhp_pkg::PH_DONE : pgmhp_pkg::PH_PIXELS;
            end
          endcase
        end
      end
    endcase
  end

  // result of this byte, if it yields one
  always_comb begin
    has_result_o         = 1'b0;
    result_o.kind        = pgmhp_pkg::KIND_HEADER;
    result_o.magic_code  = eff_magic;
    result_o.img_width   = eff_width;
    result_o.img_height  = eff_height;
    result_o.max_value   = eff_maxv;
    result_o.pixel_value = '0;
    result_o.pixel_row   = '0;
    result_o.pixel_col   = '0;
    result_o.image_done  = 1'b0;

    case (eff_phase)
      pgmhp_pkg::PH_DONE, pgmhp_pkg::PH_HALT: begin
        has_result_o = 1'b0;
      end
      pgmhp_pkg::PH_PIXELS: begin
        has_result_o         = 1'b1;
        result_o.kind        = pgmhp_pkg::KIND_PIXEL;
        result_o.pixel_value = b;
        result_o.pixel_row   = eff_row;
        result_o.pixel_col   = eff_col;
        result_o.image_done  = last_pix;
      end
      default: begin
        if (eff_in_token && !is_ws &&
            eff_tok_len >= pgmhp_pkg::TokLenW'(pgmhp_pkg::MaxTokenChars)) begin
          has_result_o        = 1'b1;
          result_o.kind       = pgmhp_pkg::KIND_ERROR;
          result_o.magic_code = '0;
          result_o.img_width  = '0;
          result_o.img_height = '0;
          result_o.max_value  = '0;
        end else if (eff_in_token && is_ws && eff_phase == pgmhp_pkg::PH_MAXVAL) begin
          // maximum value token ends: header is complete
          has_result_o        = 1'b1;
          result_o.max_value  = eff_acc;
          result_o.image_done = empty;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= pgmhp_pkg::PH_MAGIC;
      in_token_q   <= 1'b0;
      in_comment_q <= 1'b0;
      tok_len_q    <= '0;
      acc_q        <= '0;
      stopped_q    <= 1'b0;
      magic_q      <= '0;
      width_q      <= '0;
      height_q     <= '0;
      maxv_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
    end else if (ctrl_i.valid && ctrl_i.advance) begin
      phase_q      <= phase_d;
      in_token_q   <= in_token_d;
      in_comment_q <= in_comment_d;
      tok_len_q    <= tok_len_d;
      acc_q        <= acc_d;
      stopped_q    <= stopped_d;
      magic_q      <= magic_d;
      width_q      <= width_d;
      height_q     <= height_d;
      maxv_q       <= maxv_d;
      row_q        <= row_d;
      col_q        <= col_d;
    end
  end

endmodule

>>> hdl/pgmhp_out_reg.sv
// pgmhp_out_reg: result register of the parser, holds one item until taken
// depends on pgmhp_pkg

module pgmhp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pgmhp_pkg::result_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgmhp_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  pgmhp_pkg::result_t result_q;

  // free when empty or being taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
